// File: rtl/soa_pkg.sv
// ----------------------------------------------------------------------------
// soa_pkg: shared types and constants for the slab object allocator
// Sizes, pointer types, list tags, result codes, controller states and
// datapath operation codes.
// ----------------------------------------------------------------------------
package soa_pkg;

  localparam int FRAMES = 16;
  localparam int SLOTS  = 512;

  localparam int FW  = $clog2(FRAMES);      // frame number
  localparam int FPW = $clog2(FRAMES + 1);  // frame pointer incl. null
  localparam int SW  = $clog2(SLOTS);       // slot number
  localparam int SPW = $clog2(SLOTS + 1);   // slot pointer incl. null
  localparam int CW  = $clog2(FRAMES + 1);  // frame counts
  localparam int UW  = 10;                  // per-frame use count
  localparam int MW  = 5;                   // min_avail_slabs
  localparam int DW  = 10;                  // config data
  localparam int IW  = 2;                   // config index

  typedef logic [FW-1:0]  frame_t;
  typedef logic [FPW-1:0] frame_ptr_t;
  typedef logic [SW-1:0]  slot_t;
  typedef logic [SPW-1:0] slot_ptr_t;
  typedef logic [CW-1:0]  count_t;
  typedef logic [UW-1:0]  use_t;

  localparam frame_ptr_t NULL_FRAME = FPW'(FRAMES);
  localparam slot_ptr_t  NULL_SLOT  = SPW'(SLOTS);

  localparam logic [IW-1:0] CFG_OBJ_PER_SLAB = 2'd0;
  localparam logic [IW-1:0] CFG_IN_CACHE     = 2'd1;
  localparam logic [IW-1:0] CFG_MIN_AVAIL    = 2'd2;

  localparam logic [1:0] ST_GRANT     = 2'd0;
  localparam logic [1:0] ST_FAIL      = 2'd1;
  localparam logic [1:0] ST_FREE_DONE = 2'd2;

  localparam logic [2:0] FS_FULL     = 3'd0;
  localparam logic [2:0] FS_PARTIAL  = 3'd1;
  localparam logic [2:0] FS_FREE     = 3'd2;
  localparam logic [2:0] FS_CACHE    = 3'd3;
  localparam logic [2:0] FS_RELEASED = 3'd4;

  typedef enum logic [1:0] {
    TAG_UNUSED, TAG_PARTIAL, TAG_SPARE, TAG_FULL
  } tag_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CRD, S_CPOP, S_CPUSH, S_SPARE_UNLINK, S_ALLOC_PUSH, S_WALK,
    S_CLAIM, S_SLOT_RD, S_SLOT_POP, S_FULL, S_FAIL, S_FREE_WR,
    S_FREE_UNLINK, S_FREE_PARK, S_FREE_REPART, S_SWEEP, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_SWEEP, OP_CACHE_RD, OP_CACHE_POP, OP_CACHE_PUSH,
    OP_SPARE_UNLINK, OP_PARTIAL_PUSH, OP_WALK, OP_CLAIM, OP_SLOT_RD,
    OP_SLOT_POP, OP_PARTIAL_UNLINK, OP_FREE_PUSH, OP_SPARE_PUSH,
    OP_RELEASE, OP_FAIL
  } dp_op_t;

  typedef struct packed {
    logic   accept;
    logic   cfg_we;
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic cache_null;
    logic partial_empty;
    logic spare_empty;
    logic unused_none;
    logic walk_last;
    logic sweep_last;
    logic chain_null;
    logic rd_null;
    tag_t tag;
    logic use_one;
    logic free_ok;
    logic release_ok;
    logic rebuild_req;
  } sts_t;

endpackage

// File: rtl/soa_ctrl.sv
// ----------------------------------------------------------------------------
// soa_ctrl: allocator sequencer
// Steps each alloc, free and chain rebuild through the datapath operations.
// ----------------------------------------------------------------------------
module soa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          kind,
  input  logic          free_in_cache,
  input  logic          cfg_valid,
  input  soa_pkg::sts_t sts,
  output soa_pkg::cmd_t cmd,
  output logic          busy,
  output logic          done,
  output logic          cfg_ready
);

  soa_pkg::state_t state, state_next;
  logic accept;
  logic cfg_we;

  assign accept    = start && (state == soa_pkg::S_IDLE);
  assign cfg_ready = (state == soa_pkg::S_IDLE) && !start;
  assign cfg_we    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= soa_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      soa_pkg::S_IDLE: begin
        if (cfg_we && sts.rebuild_req) begin
          state_next = soa_pkg::S_SWEEP;
        end else if (accept) begin
          if (kind) begin
            state_next = free_in_cache ? soa_pkg::S_CPUSH : soa_pkg::S_FREE_WR;
          end else if (!sts.cache_null) begin
            state_next = soa_pkg::S_CRD;
          end else if (!sts.partial_empty) begin
            state_next = soa_pkg::S_SLOT_RD;
          end else if (!sts.spare_empty) begin
            state_next = soa_pkg::S_SPARE_UNLINK;
          end else if (!sts.unused_none) begin
            state_next = soa_pkg::S_WALK;
          end else begin
            state_next = soa_pkg::S_FAIL;
          end
        end
      end
      soa_pkg::S_CRD:          state_next = soa_pkg::S_CPOP;
      soa_pkg::S_CPOP:         state_next = soa_pkg::S_DONE;
      soa_pkg::S_CPUSH:        state_next = soa_pkg::S_DONE;
      soa_pkg::S_SPARE_UNLINK: state_next = soa_pkg::S_ALLOC_PUSH;
      soa_pkg::S_ALLOC_PUSH:   state_next = soa_pkg::S_SLOT_RD;
      soa_pkg::S_WALK: begin
        if (sts.walk_last) state_next = soa_pkg::S_CLAIM;
      end
      soa_pkg::S_CLAIM:        state_next = soa_pkg::S_ALLOC_PUSH;
      soa_pkg::S_SLOT_RD: begin
        state_next = sts.chain_null ? soa_pkg::S_DONE : soa_pkg::S_SLOT_POP;
      end
      soa_pkg::S_SLOT_POP: begin
        state_next = sts.rd_null ? soa_pkg::S_FULL : soa_pkg::S_DONE;
      end
      soa_pkg::S_FULL:         state_next = soa_pkg::S_DONE;
      soa_pkg::S_FAIL:         state_next = soa_pkg::S_DONE;
      soa_pkg::S_FREE_WR: begin
        if (!sts.free_ok) begin
          state_next = soa_pkg::S_DONE;
        end else if (sts.use_one) begin
          state_next = (sts.tag == soa_pkg::TAG_PARTIAL) ? soa_pkg::S_FREE_UNLINK
                                                          : soa_pkg::S_FREE_PARK;
        end else begin
          state_next = (sts.tag == soa_pkg::TAG_FULL) ? soa_pkg::S_FREE_REPART
                                                       : soa_pkg::S_DONE;
        end
      end
      soa_pkg::S_FREE_UNLINK:  state_next = soa_pkg::S_FREE_PARK;
      soa_pkg::S_FREE_PARK:    state_next = soa_pkg::S_DONE;
      soa_pkg::S_FREE_REPART:  state_next = soa_pkg::S_DONE;
      soa_pkg::S_SWEEP: begin
        if (sts.sweep_last) state_next = soa_pkg::S_IDLE;
      end
      soa_pkg::S_DONE:         state_next = soa_pkg::S_IDLE;
      default:                 state_next = soa_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd.accept = accept;
    cmd.cfg_we = cfg_we;
    cmd.op     = soa_pkg::OP_NONE;
    busy       = (state != soa_pkg::S_IDLE);
    done       = (state == soa_pkg::S_DONE);
    case (state)
      soa_pkg::S_CRD:          cmd.op = soa_pkg::OP_CACHE_RD;
      soa_pkg::S_CPOP:         cmd.op = soa_pkg::OP_CACHE_POP;
      soa_pkg::S_CPUSH:        cmd.op = soa_pkg::OP_CACHE_PUSH;
      soa_pkg::S_SPARE_UNLINK: cmd.op = soa_pkg::OP_SPARE_UNLINK;
      soa_pkg::S_ALLOC_PUSH:   cmd.op = soa_pkg::OP_PARTIAL_PUSH;
      soa_pkg::S_FREE_REPART:  cmd.op = soa_pkg::OP_PARTIAL_PUSH;
      soa_pkg::S_WALK:         cmd.op = soa_pkg::OP_WALK;
      soa_pkg::S_CLAIM:        cmd.op = soa_pkg::OP_CLAIM;
      soa_pkg::S_SLOT_RD: begin
        cmd.op = sts.chain_null ? soa_pkg::OP_FAIL : soa_pkg::OP_SLOT_RD;
      end
      soa_pkg::S_SLOT_POP:     cmd.op = soa_pkg::OP_SLOT_POP;
      soa_pkg::S_FULL:         cmd.op = soa_pkg::OP_PARTIAL_UNLINK;
      soa_pkg::S_FREE_UNLINK:  cmd.op = soa_pkg::OP_PARTIAL_UNLINK;
      soa_pkg::S_FAIL:         cmd.op = soa_pkg::OP_FAIL;
      soa_pkg::S_FREE_WR: begin
        cmd.op = sts.free_ok ? soa_pkg::OP_FREE_PUSH : soa_pkg::OP_NONE;
      end
      soa_pkg::S_FREE_PARK: begin
        cmd.op = sts.release_ok ? soa_pkg::OP_RELEASE : soa_pkg::OP_SPARE_PUSH;
      end
      soa_pkg::S_SWEEP:        cmd.op = soa_pkg::OP_SWEEP;
      default:                 cmd.op = soa_pkg::OP_NONE;
    endcase
  end

endmodule

// File: rtl/soa_dp.sv
// ----------------------------------------------------------------------------
// soa_dp: allocator datapath
// Slot chain memories, per-frame list registers, config and result registers.
// ----------------------------------------------------------------------------
module soa_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  soa_pkg::cmd_t              cmd,
  input  logic                       kind,
  input  logic [soa_pkg::FW-1:0]     free_slab,
  input  logic [soa_pkg::SW-1:0]     free_index,
  input  logic [soa_pkg::IW-1:0]     cfg_index,
  input  logic [soa_pkg::DW-1:0]     cfg_data,
  output soa_pkg::sts_t              sts,
  output logic [1:0]                 status,
  output logic                       obj_in_cache,
  output logic [soa_pkg::FW-1:0]     obj_slab,
  output logic [soa_pkg::SW-1:0]     obj_index,
  output logic                       slab_taken,
  output logic [1:0]                 from_state,
  output logic [2:0]                 to_state,
  output logic [soa_pkg::CW-1:0]     slabs_held
);

  // memories
  soa_pkg::slot_ptr_t cache_mem [soa_pkg::SLOTS];
  soa_pkg::slot_ptr_t slot_mem  [soa_pkg::FRAMES * soa_pkg::SLOTS];
  soa_pkg::slot_ptr_t cache_rdata, slot_rdata;

  // per-frame state
  soa_pkg::frame_ptr_t f_next [soa_pkg::FRAMES];
  soa_pkg::frame_ptr_t f_prev [soa_pkg::FRAMES];
  soa_pkg::slot_ptr_t  f_head [soa_pkg::FRAMES];
  soa_pkg::use_t       f_use  [soa_pkg::FRAMES];
  soa_pkg::tag_t       f_tag  [soa_pkg::FRAMES];

  soa_pkg::frame_ptr_t partial_head, spare_head;
  soa_pkg::count_t     partial_cnt, spare_cnt, held;
  soa_pkg::slot_ptr_t  cache_head;

  logic [soa_pkg::DW-1:0] obj_per_slab, in_cache_objs;
  logic [soa_pkg::MW-1:0] min_avail;

  soa_pkg::frame_t cur_f;
  soa_pkg::slot_t  s_lat;
  soa_pkg::slot_t  walk_i, sweep_j;
  logic            release_ok;

  soa_pkg::slot_ptr_t n_obj, n_cache, walk_nxt, sweep_nxt, walk_link, sweep_link;
  soa_pkg::slot_ptr_t cfg_n;
  soa_pkg::frame_t    unused_idx;
  logic               unused_none;
  soa_pkg::frame_ptr_t up, un;
  logic [soa_pkg::CW:0] avail;

  logic               slot_we, cache_we;
  logic [soa_pkg::FW+soa_pkg::SW-1:0] slot_waddr;
  soa_pkg::slot_ptr_t slot_wdata, cache_wdata;
  soa_pkg::slot_t     cache_waddr;

  // clamp register values into the supported ranges
  always_comb begin
    if (obj_per_slab == '0) begin
      n_obj = soa_pkg::SPW'(1);
    end else if (obj_per_slab > soa_pkg::DW'(soa_pkg::SLOTS)) begin
      n_obj = soa_pkg::NULL_SLOT;
    end else begin
      n_obj = soa_pkg::SPW'(obj_per_slab);
    end
    n_cache = (in_cache_objs > soa_pkg::DW'(soa_pkg::SLOTS)) ? soa_pkg::NULL_SLOT
                                                          : soa_pkg::SPW'(in_cache_objs);
    cfg_n   = (cfg_data > soa_pkg::DW'(soa_pkg::SLOTS)) ? soa_pkg::NULL_SLOT
                                                     : soa_pkg::SPW'(cfg_data);
  end

  // lowest unused frame
  always_comb begin
    unused_none = 1'b1;
    unused_idx  = '0;
    for (int k = soa_pkg::FRAMES - 1; k >= 0; k--) begin
      if (f_tag[k] == soa_pkg::TAG_UNUSED) begin
        unused_none = 1'b0;
        unused_idx  = soa_pkg::FW'(k);
      end
    end
  end

  assign walk_nxt   = soa_pkg::SPW'(walk_i) + soa_pkg::SPW'(1);
  assign sweep_nxt  = soa_pkg::SPW'(sweep_j) + soa_pkg::SPW'(1);
  assign walk_link  = (walk_nxt < n_obj) ? walk_nxt : soa_pkg::NULL_SLOT;
  assign sweep_link = (sweep_nxt < n_cache) ? sweep_nxt : soa_pkg::NULL_SLOT;
  assign avail      = (soa_pkg::CW+1)'(1) + (soa_pkg::CW+1)'(partial_cnt)
                    + (soa_pkg::CW+1)'(spare_cnt);
  assign up         = f_prev[cur_f];
  assign un         = f_next[cur_f];

  always_comb begin
    sts.cache_null    = (cache_head >= soa_pkg::NULL_SLOT);
    sts.partial_empty = (partial_head >= soa_pkg::NULL_FRAME);
    sts.spare_empty   = (spare_head >= soa_pkg::NULL_FRAME);
    sts.unused_none   = unused_none;
    sts.walk_last     = (walk_nxt >= n_obj);
    sts.sweep_last    = (sweep_nxt >= n_cache);
    sts.chain_null    = (f_head[cur_f] >= soa_pkg::NULL_SLOT);
    sts.rd_null       = (slot_rdata >= soa_pkg::NULL_SLOT);
    sts.tag           = f_tag[cur_f];
    sts.use_one       = (f_use[cur_f] == soa_pkg::UW'(1));
    sts.free_ok       = (f_tag[cur_f] inside {soa_pkg::TAG_PARTIAL, soa_pkg::TAG_FULL})
                        && (f_use[cur_f] != '0);
    sts.release_ok    = release_ok;
    sts.rebuild_req   = (cfg_index == soa_pkg::CFG_IN_CACHE) && (cfg_data != '0);
  end

  // memory ports
  always_comb begin
    slot_we     = (cmd.op == soa_pkg::OP_WALK) || (cmd.op == soa_pkg::OP_FREE_PUSH);
    slot_waddr  = (cmd.op == soa_pkg::OP_WALK) ? {cur_f, walk_i} : {cur_f, s_lat};
    slot_wdata  = (cmd.op == soa_pkg::OP_WALK) ? walk_link : f_head[cur_f];
    cache_we    = (cmd.op == soa_pkg::OP_SWEEP) || (cmd.op == soa_pkg::OP_CACHE_PUSH);
    cache_waddr = (cmd.op == soa_pkg::OP_SWEEP) ? sweep_j : s_lat;
    cache_wdata = (cmd.op == soa_pkg::OP_SWEEP) ? sweep_link : cache_head;
  end

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (cmd.op == soa_pkg::OP_SLOT_RD) begin
      slot_rdata <= slot_mem[{cur_f, f_head[cur_f][soa_pkg::SW-1:0]}];
    end
  end

  always_ff @(posedge clk) begin
    if (cache_we) cache_mem[cache_waddr] <= cache_wdata;
    if (cmd.op == soa_pkg::OP_CACHE_RD) begin
      cache_rdata <= cache_mem[cache_head[soa_pkg::SW-1:0]];
    end
  end

  // list and counter state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_head  <= soa_pkg::NULL_FRAME;
      spare_head    <= soa_pkg::NULL_FRAME;
      partial_cnt   <= '0;
      spare_cnt     <= '0;
      held          <= '0;
      cache_head    <= soa_pkg::NULL_SLOT;
      obj_per_slab  <= soa_pkg::DW'(512);
      in_cache_objs <= '0;
      min_avail     <= soa_pkg::MW'(2);
      for (int k = 0; k < soa_pkg::FRAMES; k++) begin
        f_use[k] <= '0;
        f_tag[k] <= soa_pkg::TAG_UNUSED;
      end
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          soa_pkg::CFG_OBJ_PER_SLAB: obj_per_slab <= cfg_data;
          soa_pkg::CFG_IN_CACHE: begin
            in_cache_objs <= cfg_data;
            cache_head    <= (cfg_n != '0) ? '0 : soa_pkg::NULL_SLOT;
            sweep_j       <= '0;
          end
          soa_pkg::CFG_MIN_AVAIL:    min_avail <= cfg_data[soa_pkg::MW-1:0];
          default: ;
        endcase
      end

      if (cmd.accept) begin
        s_lat        <= free_index;
        walk_i       <= '0;
        status       <= kind ? soa_pkg::ST_FREE_DONE : soa_pkg::ST_GRANT;
        obj_in_cache <= 1'b0;
        obj_slab     <= '0;
        obj_index    <= '0;
        slab_taken   <= 1'b0;
        from_state   <= kind ? soa_pkg::FS_FREE[1:0] : 2'd0;
        to_state     <= kind ? soa_pkg::FS_FREE : 3'd0;
        if (kind) begin
          cur_f <= free_slab;
        end else if (partial_head < soa_pkg::NULL_FRAME) begin
          cur_f <= partial_head[soa_pkg::FW-1:0];
        end else if (spare_head < soa_pkg::NULL_FRAME) begin
          cur_f <= spare_head[soa_pkg::FW-1:0];
        end else begin
          cur_f <= unused_idx;
        end
      end

      case (cmd.op)
        soa_pkg::OP_SWEEP: sweep_j <= sweep_nxt[soa_pkg::SW-1:0];
        soa_pkg::OP_CACHE_POP: begin
          cache_head   <= cache_rdata;
          obj_in_cache <= 1'b1;
          obj_index    <= cache_head[soa_pkg::SW-1:0];
        end
        soa_pkg::OP_CACHE_PUSH: begin
          cache_head <= soa_pkg::SPW'(s_lat);
          from_state <= soa_pkg::FS_CACHE[1:0];
          to_state   <= soa_pkg::FS_CACHE;
        end
        soa_pkg::OP_SPARE_UNLINK: begin
          if (up < soa_pkg::NULL_FRAME) f_next[up[soa_pkg::FW-1:0]] <= un;
          else spare_head <= un;
          if (un < soa_pkg::NULL_FRAME) f_prev[un[soa_pkg::FW-1:0]] <= up;
          if (spare_cnt != '0) spare_cnt <= spare_cnt - soa_pkg::CW'(1);
        end
        soa_pkg::OP_PARTIAL_UNLINK: begin
          if (up < soa_pkg::NULL_FRAME) f_next[up[soa_pkg::FW-1:0]] <= un;
          else partial_head <= un;
          if (un < soa_pkg::NULL_FRAME) f_prev[un[soa_pkg::FW-1:0]] <= up;
          if (partial_cnt != '0) partial_cnt <= partial_cnt - soa_pkg::CW'(1);
          f_tag[cur_f] <= soa_pkg::TAG_FULL;
        end
        soa_pkg::OP_PARTIAL_PUSH: begin
          f_prev[cur_f] <= soa_pkg::NULL_FRAME;
          f_next[cur_f] <= partial_head;
          if (partial_head < soa_pkg::NULL_FRAME) begin
            f_prev[partial_head[soa_pkg::FW-1:0]] <= soa_pkg::FPW'(cur_f);
          end
          partial_head <= soa_pkg::FPW'(cur_f);
          partial_cnt  <= partial_cnt + soa_pkg::CW'(1);
          f_tag[cur_f] <= soa_pkg::TAG_PARTIAL;
        end
        soa_pkg::OP_SPARE_PUSH: begin
          f_prev[cur_f] <= soa_pkg::NULL_FRAME;
          f_next[cur_f] <= spare_head;
          if (spare_head < soa_pkg::NULL_FRAME) begin
            f_prev[spare_head[soa_pkg::FW-1:0]] <= soa_pkg::FPW'(cur_f);
          end
          spare_head   <= soa_pkg::FPW'(cur_f);
          spare_cnt    <= spare_cnt + soa_pkg::CW'(1);
          f_tag[cur_f] <= soa_pkg::TAG_SPARE;
          to_state     <= soa_pkg::FS_FREE;
        end
        soa_pkg::OP_WALK: walk_i <= walk_nxt[soa_pkg::SW-1:0];
        soa_pkg::OP_CLAIM: begin
          f_head[cur_f] <= '0;
          f_use[cur_f]  <= '0;
          held          <= held + soa_pkg::CW'(1);
          slab_taken    <= 1'b1;
        end
        soa_pkg::OP_SLOT_POP: begin
          f_head[cur_f] <= slot_rdata;
          f_use[cur_f]  <= f_use[cur_f] + soa_pkg::UW'(1);
          obj_slab      <= cur_f;
          obj_index     <= f_head[cur_f][soa_pkg::SW-1:0];
        end
        soa_pkg::OP_FREE_PUSH: begin
          f_head[cur_f] <= soa_pkg::SPW'(s_lat);
          f_use[cur_f]  <= f_use[cur_f] - soa_pkg::UW'(1);
          release_ok    <= avail > (soa_pkg::CW+1)'(min_avail);
          from_state    <= (f_tag[cur_f] == soa_pkg::TAG_FULL) ? soa_pkg::FS_FULL[1:0]
                                                               : soa_pkg::FS_PARTIAL[1:0];
          to_state      <= soa_pkg::FS_PARTIAL;
        end
        soa_pkg::OP_RELEASE: begin
          f_tag[cur_f] <= soa_pkg::TAG_UNUSED;
          if (held != '0) held <= held - soa_pkg::CW'(1);
          to_state     <= soa_pkg::FS_RELEASED;
        end
        soa_pkg::OP_FAIL: begin
          status     <= soa_pkg::ST_FAIL;
          slab_taken <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign slabs_held = held;

endmodule

// File: rtl/slab_object_allocator.sv
// ----------------------------------------------------------------------------
// slab_object_allocator: object handle allocator for one slab cache
// Serves allocs from the in-cache chain, partial and spare frames, or a newly
// claimed frame, and takes frees back into their chains.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: raise start with kind and the free fields; the command
//   is taken at an edge with start high and busy low. busy stays high until
//   the result has been shown.
//   Result channel: done is high for exactly one cycle with status and the
//   object fields; the receiver cannot stall it and must take it then.
//   Steps: an in-cache alloc reads then pops the in-cache chain, and an
//   in-cache free is a single push; a free into a frame may unlink and park
//   it or move a full one back to partial; a spare frame is unlinked and
//   pushed to partial before its alloc, and a frame that fills is unlinked
//   from partial. A claimed frame's chain of obj_per_slab slots (taken as 1
//   to 512) is linked one slot per cycle through the memory port.
//   A new command is taken at the earliest in the cycle after done.
//   Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data, taken
//   while idle. Writing in_cache_objs rebuilds the in-cache chain, one entry
//   per cycle, over in_cache_objs entries (capped at 512) with busy high.
//   Reset: all frames unused, lists empty, in-cache chain empty.
// ----------------------------------------------------------------------------
module slab_object_allocator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       kind,
  input  logic                       free_in_cache,
  input  logic [soa_pkg::FW-1:0]     free_slab,
  input  logic [soa_pkg::SW-1:0]     free_index,
  output logic                       done,
  output logic [1:0]                 status,
  output logic                       obj_in_cache,
  output logic [soa_pkg::FW-1:0]     obj_slab,
  output logic [soa_pkg::SW-1:0]     obj_index,
  output logic                       slab_taken,
  output logic [1:0]                 from_state,
  output logic [2:0]                 to_state,
  output logic [soa_pkg::CW-1:0]     slabs_held,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [soa_pkg::IW-1:0]     cfg_index,
  input  logic [soa_pkg::DW-1:0]     cfg_data
);

  soa_pkg::cmd_t cmd;
  soa_pkg::sts_t sts;

  soa_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .kind          (kind),
    .free_in_cache (free_in_cache),
    .cfg_valid     (cfg_valid),
    .sts           (sts),
    .cmd           (cmd),
    .busy          (busy),
    .done          (done),
    .cfg_ready     (cfg_ready)
  );

  soa_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .kind          (kind),
    .free_slab     (free_slab),
    .free_index    (free_index),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sts           (sts),
    .status        (status),
    .obj_in_cache  (obj_in_cache),
    .obj_slab      (obj_slab),
    .obj_index     (obj_index),
    .slab_taken    (slab_taken),
    .from_state    (from_state),
    .to_state      (to_state),
    .slabs_held    (slabs_held)
  );

endmodule

// File: rtl/soa_checker.sv
// ----------------------------------------------------------------------------
// soa_checker: port-level checks for the slab object allocator
// Watches the command, result and config ports over time.
// ----------------------------------------------------------------------------
module soa_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic                   done,
  input logic [1:0]             status,
  input logic                   obj_in_cache,
  input logic [soa_pkg::SW-1:0] obj_index,
  input logic                   slab_taken,
  input logic [soa_pkg::CW-1:0] slabs_held,
  input logic                   cfg_ready
);

  // never two results in a row
  a_single_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  // a taken command keeps the block busy
  a_busy_after_start: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after command taken");

  a_fail_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == soa_pkg::ST_FAIL) |-> (!slab_taken && obj_index == '0))
    else $error("failed alloc carries object fields");

  a_free_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == soa_pkg::ST_FREE_DONE) |-> (!obj_in_cache && !slab_taken))
    else $error("free result carries alloc fields");

  a_held_range: assert property (@(posedge clk) disable iff (rst)
    (done || cfg_ready) |-> (slabs_held <= soa_pkg::CW'(soa_pkg::FRAMES)))
    else $error("held frame count out of range");

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);
